[design/tsi_pkg.sv]
// Package for the true strength index block: widths, constants, enum types.
// No dependencies; every other design file refers to it by scoped names.

package tsi_pkg;

	localparam int SAMPLE_W      = 32;
	localparam int MOM_W         = SAMPLE_W + 1;
	localparam int EMA_FRAC_BITS = 24;
	localparam int IDX_FRAC      = 16;
	localparam int EMA_SHIFT     = EMA_FRAC_BITS - IDX_FRAC;
	localparam int EMA_W         = 48;
	localparam int SHM_W         = MOM_W + EMA_SHIFT;
	localparam int DIFF_W        = EMA_W + 1;
	localparam int MAG3_W        = DIFF_W + 1;
	localparam int PP_W          = DIFF_W + 2;

	localparam int ALPHA_W     = 17;
	localparam int ALPHA_FRAC  = 16;
	localparam int DIGIT_W     = 2;
	localparam int DIGITS      = ALPHA_FRAC / DIGIT_W;
	localparam int DIGIT_CNT_W = $clog2(DIGITS);

	localparam int WARMUP_W = 16;
	localparam int THRESH_W = 23;
	localparam int INDEX_W  = 24;
	localparam int QUO_W    = INDEX_W - 1;
	localparam int CNT_W    = 32;

	localparam int SCALE     = 100;
	localparam int SCALE_W   = 7;
	localparam int PROD_W    = EMA_W + SCALE_W;
	localparam int REM_W     = EMA_W - 1;
	localparam int PRE_SHIFT = QUO_W - IDX_FRAC;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	localparam int APB_DW    = 32;
	localparam int APB_AW    = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [ALPHA_W-1:0]  ALPHA_ONE      = ALPHA_W'(2 ** ALPHA_FRAC);
	localparam logic [ALPHA_W-1:0]  ALPHA_FAST_RST = ALPHA_W'(26214);
	localparam logic [ALPHA_W-1:0]  ALPHA_SLOW_RST = ALPHA_W'(8738);
	localparam logic [WARMUP_W-1:0] WARMUP_RST     = '0;
	localparam logic [THRESH_W-1:0] THRESH_RST     = THRESH_W'(1638400);
	localparam logic [QUO_W-1:0]    INDEX_FULL     = QUO_W'(SCALE * (2 ** IDX_FRAC));
	localparam logic [EMA_W-1:0]    EMA_MAX        = {1'b0, {(EMA_W-1){1'b1}}};
	localparam logic [CNT_W-1:0]    CNT_MAX        = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ALPHA_FAST,
		REG_ALPHA_SLOW,
		REG_WARMUP,
		REG_THRESH
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_MOM_FAST,
		OP_ABS_FAST,
		OP_MOM_SLOW,
		OP_ABS_SLOW
	} ema_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_EMA_GO,
		S_EMA_WAIT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} tsi_state_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_ABS,
		E_TRIPLE,
		E_MUL,
		E_FIN
	} ema_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_PREP,
		D_STEP,
		D_FIN
	} div_state_t;

endpackage

[design/tsi_stream_if.sv]
// Word channels of the true strength index block: sample in, result out.
// Depends on tsi_pkg for the payload widths.

interface tsi_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsi_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tsi_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [tsi_pkg::INDEX_W-1:0] index_value;
	logic                               index_valid;
	logic                               zero_cross;
	logic                               strong_res;
	logic [tsi_pkg::CNT_W-1:0]          cross_count;
	logic [tsi_pkg::CNT_W-1:0]          strong_count;
	logic [tsi_pkg::CNT_W-1:0]          sample_count;

	modport source (
		output valid, output index_value, output index_valid, output zero_cross,
		output strong_res, output cross_count, output strong_count, output sample_count,
		input ready
	);
	modport sink (
		input valid, input index_value, input index_valid, input zero_cross,
		input strong_res, input cross_count, input strong_count, input sample_count,
		output ready
	);
endinterface

[design/true_strength_index.sv]
// True strength index: one signed Q16.16 sample word in, one result word out per sample.
// The first sample after reset only seeds the previous sample and goes straight to the
// output register; a sample before warm-up runs the four EMA updates but not the divider;
// a full sample runs both, and any sample may wait for the output register. The work is
// done by the shared EMA unit (alpha taken two bits per cycle) and the restoring divider
// (one quotient bit per cycle). A new sample is taken while the previous result still
// waits in the output register. Registers sit at byte addresses 0, 4, 8, 12:
// alpha_fast, alpha_slow, warmup_samples, strong_thresh; write them only while idle.
// Depends on tsi_pkg, tsi_stream_if, tsi_ema_unit and tsi_div.

module true_strength_index (
	input  logic                          clk,
	input  logic                          arst_n,
	tsi_in_if.sink                        samples,
	tsi_out_if.source                     results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsi_pkg::APB_AW-1:0]    paddr,
	input  logic [tsi_pkg::APB_DW-1:0]    pwdata,
	output logic [tsi_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	function automatic logic [tsi_pkg::CNT_W-1:0] sat_inc(input logic [tsi_pkg::CNT_W-1:0] c);
		return (c == tsi_pkg::CNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [tsi_pkg::EMA_W-1:0] ema_mag(input logic [tsi_pkg::MOM_W-1:0] m);
		logic [tsi_pkg::SHM_W-1:0] shm;
		shm = tsi_pkg::SHM_W'(m) << tsi_pkg::EMA_SHIFT;
		if ((shm >> (tsi_pkg::EMA_W - 1)) != '0) begin
			return tsi_pkg::EMA_MAX;
		end
		return tsi_pkg::EMA_W'(shm);
	endfunction

	tsi_pkg::tsi_state_t state_q, state_d;
	tsi_pkg::ema_op_t    op_q;
	tsi_pkg::reg_idx_t   reg_sel;

	logic [tsi_pkg::ALPHA_W-1:0]  alpha_fast_q;
	logic [tsi_pkg::ALPHA_W-1:0]  alpha_slow_q;
	logic [tsi_pkg::WARMUP_W-1:0] warmup_q;
	logic [tsi_pkg::THRESH_W-1:0] thresh_q;

	logic [tsi_pkg::SAMPLE_W-1:0]       last_sample_q;
	logic                               seeded_q;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_mf_q;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_af_q;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_ms_q;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_as_q;
	logic [tsi_pkg::INDEX_W-1:0]        last_index_q;
	logic [tsi_pkg::CNT_W-1:0]          items_q;
	logic [tsi_pkg::CNT_W-1:0]          cross_total_q;
	logic [tsi_pkg::CNT_W-1:0]          strong_total_q;

	logic [tsi_pkg::MOM_W-1:0]          mom_q;
	logic signed [tsi_pkg::EMA_W-1:0]   x_mom_q;
	logic signed [tsi_pkg::EMA_W-1:0]   x_abs_q;
	logic                               seed_item_q;
	logic                               warm_q;
	logic signed [tsi_pkg::INDEX_W-1:0] idx_q;

	logic                               out_valid_q;
	logic signed [tsi_pkg::INDEX_W-1:0] out_index_q;
	logic                               out_ivalid_q;
	logic                               out_cross_q;
	logic                               out_strong_q;
	logic [tsi_pkg::CNT_W-1:0]          out_ccount_q;
	logic [tsi_pkg::CNT_W-1:0]          out_scount_q;
	logic [tsi_pkg::CNT_W-1:0]          out_count_q;

	logic                               in_acc;
	logic                               cfg_wr;
	logic                               ema_start;
	logic                               ema_done;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_e;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_x;
	logic [tsi_pkg::ALPHA_W-1:0]        ema_alpha;
	logic signed [tsi_pkg::EMA_W-1:0]   ema_res;
	logic                               div_start;
	logic                               div_done;
	logic signed [tsi_pkg::INDEX_W-1:0] div_quo;
	logic                               out_load;

	logic [tsi_pkg::MOM_W-1:0]          mom_mag;
	logic [tsi_pkg::EMA_W-1:0]          x_mag;
	logic                               fin_valid;
	logic                               fin_cross;
	logic                               fin_strong;
	logic [tsi_pkg::INDEX_W-1:0]        idx_abs;
	logic [tsi_pkg::INDEX_W-1:0]        out_abs;

	assign in_acc  = samples.valid && samples.ready;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = tsi_pkg::reg_idx_t'(paddr[tsi_pkg::APB_AW-1:2]);

	always_comb begin
		unique case (reg_sel)
			tsi_pkg::REG_ALPHA_FAST: prdata = tsi_pkg::APB_DW'(alpha_fast_q);
			tsi_pkg::REG_ALPHA_SLOW: prdata = tsi_pkg::APB_DW'(alpha_slow_q);
			tsi_pkg::REG_WARMUP:     prdata = tsi_pkg::APB_DW'(warmup_q);
			tsi_pkg::REG_THRESH:     prdata = tsi_pkg::APB_DW'(thresh_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_fast_q <= tsi_pkg::ALPHA_FAST_RST;
			alpha_slow_q <= tsi_pkg::ALPHA_SLOW_RST;
			warmup_q     <= tsi_pkg::WARMUP_RST;
			thresh_q     <= tsi_pkg::THRESH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				tsi_pkg::REG_ALPHA_FAST: alpha_fast_q <= pwdata[tsi_pkg::ALPHA_W-1:0];
				tsi_pkg::REG_ALPHA_SLOW: alpha_slow_q <= pwdata[tsi_pkg::ALPHA_W-1:0];
				tsi_pkg::REG_WARMUP:     warmup_q     <= pwdata[tsi_pkg::WARMUP_W-1:0];
				tsi_pkg::REG_THRESH:     thresh_q     <= pwdata[tsi_pkg::THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (op_q)
			tsi_pkg::OP_MOM_FAST: begin
				ema_e = ema_mf_q; ema_x = x_mom_q; ema_alpha = alpha_fast_q;
			end
			tsi_pkg::OP_ABS_FAST: begin
				ema_e = ema_af_q; ema_x = x_abs_q; ema_alpha = alpha_fast_q;
			end
			tsi_pkg::OP_MOM_SLOW: begin
				ema_e = ema_ms_q; ema_x = ema_mf_q; ema_alpha = alpha_slow_q;
			end
			tsi_pkg::OP_ABS_SLOW: begin
				ema_e = ema_as_q; ema_x = ema_af_q; ema_alpha = alpha_slow_q;
			end
			default: begin
				ema_e = ema_mf_q; ema_x = x_mom_q; ema_alpha = alpha_fast_q;
			end
		endcase
	end

	tsi_ema_unit u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ema_start),
		.e      (ema_e),
		.x      (ema_x),
		.alpha  (ema_alpha),
		.done   (ema_done),
		.e_next (ema_res)
	);

	tsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ema_ms_q),
		.den    (ema_as_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		ema_start     = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			tsi_pkg::S_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = seeded_q ? tsi_pkg::S_PREP : tsi_pkg::S_FINISH;
				end
			end
			tsi_pkg::S_PREP: state_d = tsi_pkg::S_EMA_GO;
			tsi_pkg::S_EMA_GO: begin
				ema_start = 1'b1;
				state_d   = tsi_pkg::S_EMA_WAIT;
			end
			tsi_pkg::S_EMA_WAIT: begin
				if (ema_done) begin
					if (op_q == tsi_pkg::OP_ABS_SLOW) begin
						state_d = warm_q ? tsi_pkg::S_DIV_GO : tsi_pkg::S_FINISH;
					end else begin
						state_d = tsi_pkg::S_EMA_GO;
					end
				end
			end
			tsi_pkg::S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = tsi_pkg::S_DIV_WAIT;
			end
			tsi_pkg::S_DIV_WAIT: if (div_done) state_d = tsi_pkg::S_FINISH;
			tsi_pkg::S_FINISH: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = tsi_pkg::S_IDLE;
				end
			end
			default: state_d = tsi_pkg::S_IDLE;
		endcase
	end

	assign mom_mag    = mom_q[tsi_pkg::MOM_W-1] ? (~mom_q + 1'b1) : mom_q;
	assign x_mag      = ema_mag(mom_mag);
	assign fin_valid  = !seed_item_q && warm_q;
	assign idx_abs    = idx_q[tsi_pkg::INDEX_W-1] ? (~idx_q + 1'b1) : idx_q;
	assign fin_cross  = fin_valid && (last_index_q[tsi_pkg::INDEX_W-1] != idx_q[tsi_pkg::INDEX_W-1]);
	assign fin_strong = fin_valid && (idx_abs[tsi_pkg::QUO_W-1:0] > thresh_q);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q  <= '0;
			seeded_q       <= 1'b0;
			ema_mf_q       <= '0;
			ema_af_q       <= '0;
			ema_ms_q       <= '0;
			ema_as_q       <= '0;
			last_index_q   <= '0;
			items_q        <= '0;
			cross_total_q  <= '0;
			strong_total_q <= '0;
			op_q           <= tsi_pkg::OP_MOM_FAST;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_acc) begin
				last_sample_q <= samples.sample;
				seeded_q      <= 1'b1;
				items_q       <= sat_inc(items_q);
				op_q          <= tsi_pkg::OP_MOM_FAST;
			end
			if (state_q == tsi_pkg::S_EMA_WAIT && ema_done) begin
				unique case (op_q)
					tsi_pkg::OP_MOM_FAST: ema_mf_q <= ema_res;
					tsi_pkg::OP_ABS_FAST: ema_af_q <= ema_res;
					tsi_pkg::OP_MOM_SLOW: ema_ms_q <= ema_res;
					tsi_pkg::OP_ABS_SLOW: ema_as_q <= ema_res;
					default: begin
					end
				endcase
				op_q <= tsi_pkg::ema_op_t'(op_q + 2'd1);
			end
			if (out_load) begin
				if (!seed_item_q) begin
					last_index_q <= idx_q;
				end
				if (fin_cross) begin
					cross_total_q <= sat_inc(cross_total_q);
				end
				if (fin_strong) begin
					strong_total_q <= sat_inc(strong_total_q);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-sample working registers and output word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mom_q       <= {samples.sample[tsi_pkg::SAMPLE_W-1], samples.sample}
				- {last_sample_q[tsi_pkg::SAMPLE_W-1], last_sample_q};
			seed_item_q <= !seeded_q;
			warm_q      <= seeded_q && (items_q >= tsi_pkg::CNT_W'(warmup_q));
			idx_q       <= '0;
		end
		if (state_q == tsi_pkg::S_PREP) begin
			x_abs_q <= x_mag;
			x_mom_q <= mom_q[tsi_pkg::MOM_W-1] ? (~x_mag + 1'b1) : x_mag;
		end
		if (state_q == tsi_pkg::S_DIV_WAIT && div_done) begin
			idx_q <= div_quo;
		end
		if (out_load) begin
			out_index_q  <= idx_q;
			out_ivalid_q <= fin_valid;
			out_cross_q  <= fin_cross;
			out_strong_q <= fin_strong;
			out_ccount_q <= fin_cross ? sat_inc(cross_total_q) : cross_total_q;
			out_scount_q <= fin_strong ? sat_inc(strong_total_q) : strong_total_q;
			out_count_q  <= items_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.index_value  = out_index_q;
	assign results.index_valid  = out_ivalid_q;
	assign results.zero_cross   = out_cross_q;
	assign results.strong_res   = out_strong_q;
	assign results.cross_count  = out_ccount_q;
	assign results.strong_count = out_scount_q;
	assign results.sample_count = out_count_q;

	assign out_abs = out_index_q[tsi_pkg::INDEX_W-1] ? (~out_index_q + 1'b1) : out_index_q;

	a_ema_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ema_done |-> state_q == tsi_pkg::S_EMA_WAIT)
		else $error("EMA unit finished outside its wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == tsi_pkg::S_DIV_WAIT)
		else $error("divider finished outside its wait state");

	a_invalid_word_clear: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.index_valid |->
			results.index_value == '0 && !results.zero_cross && !results.strong_res)
		else $error("word without index carries index or flags");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> out_abs <= tsi_pkg::INDEX_W'(tsi_pkg::INDEX_FULL))
		else $error("index magnitude above full scale");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample taken while previous one still in work");

endmodule

[design/tsi_ema_unit.sv]
// Shared EMA update unit: e + alpha * (x - e) / 65536, step rounded toward zero.
// Alpha is consumed two bits per cycle, LSB first, through a shift register.
// Depends on tsi_pkg.

module tsi_ema_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tsi_pkg::EMA_W-1:0]  e,
	input  logic signed [tsi_pkg::EMA_W-1:0]  x,
	input  logic [tsi_pkg::ALPHA_W-1:0]       alpha,
	output logic                              done,
	output logic signed [tsi_pkg::EMA_W-1:0]  e_next
);

	tsi_pkg::ema_state_t state_q, state_d;

	logic [tsi_pkg::DIFF_W-1:0]      d_q;
	logic [tsi_pkg::EMA_W-1:0]       e_q;
	logic [tsi_pkg::DIFF_W-1:0]      mag_q;
	logic [tsi_pkg::MAG3_W-1:0]      mag3_q;
	logic                            neg_q;
	logic                            full_q;
	logic [tsi_pkg::ALPHA_FRAC-1:0]  digits_q;
	logic [tsi_pkg::DIGIT_CNT_W-1:0] cnt_q;
	logic [tsi_pkg::DIFF_W-1:0]      acc_q;

	logic [tsi_pkg::ALPHA_W-1:0] alpha_sat;
	logic [tsi_pkg::PP_W-1:0]    pp;
	logic [tsi_pkg::PP_W-1:0]    sum;
	logic [tsi_pkg::DIFF_W-1:0]  step;
	logic [tsi_pkg::DIFF_W-1:0]  e_ext;
	logic [tsi_pkg::DIFF_W-1:0]  upd;
	logic                        last_digit;

	assign alpha_sat  = (alpha > tsi_pkg::ALPHA_ONE) ? tsi_pkg::ALPHA_ONE : alpha;
	assign last_digit = (cnt_q == tsi_pkg::DIGIT_CNT_W'(tsi_pkg::DIGITS - 1));

	always_comb begin
		case (digits_q[tsi_pkg::DIGIT_W-1:0])
			2'd0:    pp = '0;
			2'd1:    pp = tsi_pkg::PP_W'(mag_q);
			2'd2:    pp = tsi_pkg::PP_W'({mag_q, 1'b0});
			default: pp = tsi_pkg::PP_W'(mag3_q);
		endcase
	end

	assign sum    = tsi_pkg::PP_W'(acc_q) + pp;
	assign step   = full_q ? mag_q : acc_q;
	assign e_ext  = {e_q[tsi_pkg::EMA_W-1], e_q};
	assign upd    = neg_q ? (e_ext - step) : (e_ext + step);
	assign e_next = upd[tsi_pkg::EMA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsi_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			tsi_pkg::E_IDLE:   if (start) state_d = tsi_pkg::E_ABS;
			tsi_pkg::E_ABS:    state_d = tsi_pkg::E_TRIPLE;
			tsi_pkg::E_TRIPLE: state_d = tsi_pkg::E_MUL;
			tsi_pkg::E_MUL:    if (last_digit) state_d = tsi_pkg::E_FIN;
			tsi_pkg::E_FIN: begin
				done    = 1'b1;
				state_d = tsi_pkg::E_IDLE;
			end
			default: state_d = tsi_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tsi_pkg::E_IDLE: begin
				if (start) begin
					d_q      <= {x[tsi_pkg::EMA_W-1], x} - {e[tsi_pkg::EMA_W-1], e};
					e_q      <= e;
					full_q   <= alpha_sat[tsi_pkg::ALPHA_FRAC];
					digits_q <= alpha_sat[tsi_pkg::ALPHA_FRAC-1:0];
					acc_q    <= '0;
					cnt_q    <= '0;
				end
			end
			tsi_pkg::E_ABS: begin
				neg_q <= d_q[tsi_pkg::DIFF_W-1];
				mag_q <= d_q[tsi_pkg::DIFF_W-1] ? (~d_q + 1'b1) : d_q;
			end
			tsi_pkg::E_TRIPLE: begin
				mag3_q <= {mag_q, 1'b0} + {1'b0, mag_q};
			end
			tsi_pkg::E_MUL: begin
				acc_q    <= tsi_pkg::DIFF_W'(sum >> tsi_pkg::DIGIT_W);
				digits_q <= digits_q >> tsi_pkg::DIGIT_W;
				cnt_q    <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[design/tsi_div.sv]
// Serial ratio unit: 100 * num / den in Q8.16, truncated, saturated to +-100.
// Restoring division, one quotient bit per cycle. Depends on tsi_pkg.

module tsi_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tsi_pkg::EMA_W-1:0]   num,
	input  logic signed [tsi_pkg::EMA_W-1:0]   den,
	output logic                               done,
	output logic signed [tsi_pkg::INDEX_W-1:0] quo
);

	tsi_pkg::div_state_t state_q, state_d;

	logic                            neg_q;
	logic [tsi_pkg::EMA_W-1:0]       n_q;
	logic                            dpos_q;
	logic [tsi_pkg::REM_W-1:0]       dn_q;
	logic                            zero_q;
	logic                            sat_q;
	logic [tsi_pkg::REM_W-1:0]       rem_q;
	logic [tsi_pkg::QUO_W-1:0]       low_q;
	logic [tsi_pkg::QUO_W-1:0]       q_q;
	logic [tsi_pkg::DIV_CNT_W-1:0]   cnt_q;

	logic                          big;
	logic [tsi_pkg::PROD_W-1:0]    prod;
	logic [tsi_pkg::EMA_W-1:0]     trial;
	logic [tsi_pkg::EMA_W-1:0]     dn_ext;
	logic                          ge;
	logic [tsi_pkg::QUO_W-1:0]     qmag;
	logic [tsi_pkg::INDEX_W-1:0]   qext;
	logic                          last_step;

	assign dn_ext    = {1'b0, dn_q};
	assign big       = (n_q >= dn_ext);
	assign prod      = tsi_pkg::PROD_W'(n_q) * tsi_pkg::PROD_W'(tsi_pkg::SCALE);
	assign trial     = {rem_q, low_q[tsi_pkg::QUO_W-1]};
	assign ge        = (trial >= dn_ext);
	assign last_step = (cnt_q == tsi_pkg::DIV_CNT_W'(tsi_pkg::QUO_W - 1));
	assign qmag      = zero_q ? '0 : (sat_q ? tsi_pkg::INDEX_FULL : q_q);
	assign qext      = {1'b0, qmag};
	assign quo       = neg_q ? (~qext + 1'b1) : qext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsi_pkg::D_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			tsi_pkg::D_IDLE: if (start) state_d = tsi_pkg::D_PREP;
			tsi_pkg::D_PREP: state_d = (!dpos_q || big) ? tsi_pkg::D_FIN : tsi_pkg::D_STEP;
			tsi_pkg::D_STEP: if (last_step) state_d = tsi_pkg::D_FIN;
			tsi_pkg::D_FIN: begin
				done    = 1'b1;
				state_d = tsi_pkg::D_IDLE;
			end
			default: state_d = tsi_pkg::D_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tsi_pkg::D_IDLE: begin
				if (start) begin
					neg_q  <= num[tsi_pkg::EMA_W-1];
					n_q    <= num[tsi_pkg::EMA_W-1] ? (~num + 1'b1) : num;
					dpos_q <= !den[tsi_pkg::EMA_W-1] && (den != '0);
					dn_q   <= den[tsi_pkg::REM_W-1:0];
				end
			end
			tsi_pkg::D_PREP: begin
				zero_q <= !dpos_q;
				sat_q  <= big;
				rem_q  <= tsi_pkg::REM_W'(prod >> tsi_pkg::PRE_SHIFT);
				low_q  <= {prod[tsi_pkg::PRE_SHIFT-1:0], {tsi_pkg::IDX_FRAC{1'b0}}};
				q_q    <= '0;
				cnt_q  <= '0;
			end
			tsi_pkg::D_STEP: begin
				rem_q <= ge ? tsi_pkg::REM_W'(trial - dn_ext) : tsi_pkg::REM_W'(trial);
				low_q <= low_q << 1;
				q_q   <= {q_q[tsi_pkg::QUO_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
